### hw/rtl/cwc_pkg.sv
//==============================================================================
// cwc_pkg
// Shared types, codes and reset constants of the congestion window controller.
//==============================================================================
`default_nettype none

package cwc_pkg;

    // Default fixed point format of the congestion window.
    localparam int WIN_FRAC_BITS_DEF = 12;
    localparam int WIN_INT_BITS_DEF  = 20;

    // Configuration port geometry.
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 32;

    // Register reset values.
    localparam logic [31:0] TOTAL_RST       = 32'd1;
    localparam logic [19:0] INIT_THR_RST    = 20'd512;
    localparam logic [19:0] MIN_THR_RST     = 20'd512;
    localparam logic [19:0] TIMEOUT_WIN_RST = 20'd100;
    localparam logic [19:0] INIT_WIN_RST    = 20'd6;
    localparam logic [7:0]  BURST_RST       = 8'd32;

    // Duplicate acknowledgement handling and field limits.
    localparam logic [7:0]  DUP_LIMIT = 8'd3;
    localparam logic [7:0]  DUP_MAX   = 8'hFF;
    localparam logic [19:0] THR_MAX   = 20'hFFFFF;

    typedef enum logic [1:0] {
        OP_START   = 2'd0,
        OP_ACK     = 2'd1,
        OP_TIMEOUT = 2'd2,
        OP_NONE    = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        PH_SLOW    = 2'd0,
        PH_AVOID   = 2'd1,
        PH_RECOVER = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        CFG_TOTAL       = 3'd0,
        CFG_INIT_THR    = 3'd1,
        CFG_MIN_THR     = 3'd2,
        CFG_TIMEOUT_WIN = 3'd3,
        CFG_INIT_WIN    = 3'd4,
        CFG_BURST       = 3'd5
    } cfg_index_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVENT,
        ST_DIV,
        ST_PREP,
        ST_SEND
    } ctrl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic exec;
        logic div_start;
        logic grow;
        logic prep;
        logic emit;
    } cwc_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;
        logic div_done;
    } cwc_status_t;

endpackage

`default_nettype wire

### hw/rtl/cwc_if.sv
//==============================================================================
// cwc_if
// Valid/ready channels for event beats and result beats.
//==============================================================================
`default_nettype none

interface cwc_event_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [31:0] ack_number;

    modport source (output valid, opcode, ack_number, input ready);
    modport sink   (input valid, opcode, ack_number, output ready);
endinterface

interface cwc_result_if;
    logic        valid;
    logic        ready;
    logic [31:0] resend_first;
    logic [7:0]  resend_count;
    logic [31:0] send_first;
    logic [19:0] send_count;
    logic [31:0] window_fixed;
    logic [19:0] threshold_out;
    logic [1:0]  phase_out;
    logic [7:0]  duplicate_count;
    logic        finished;

    modport source (
        output valid, resend_first, resend_count, send_first, send_count,
               window_fixed, threshold_out, phase_out, duplicate_count, finished,
        input  ready
    );
    modport sink (
        input  valid, resend_first, resend_count, send_first, send_count,
               window_fixed, threshold_out, phase_out, duplicate_count, finished,
        output ready
    );
endinterface

`default_nettype wire

### hw/rtl/cwc_div.sv
//==============================================================================
// cwc_div
// Restoring divider that produces one quotient bit per cycle.
//==============================================================================
`default_nettype none

module cwc_div #(
    parameter int DIVIDEND_BITS = cwc_pkg::WIN_FRAC_BITS_DEF + 1,
    parameter int DIVISOR_BITS  = cwc_pkg::WIN_INT_BITS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     start,
    input  wire logic [DIVIDEND_BITS-1:0] dividend,
    input  wire logic [DIVISOR_BITS-1:0]  divisor,
    output logic                          done,
    output logic [DIVIDEND_BITS-1:0]      quotient
);

    localparam int CNT_BITS = $clog2(DIVIDEND_BITS + 1);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [CNT_BITS-1:0]      cnt_reg, cnt_next;
    logic [DIVIDEND_BITS-1:0] quo_reg, quo_next;
    logic [DIVISOR_BITS-1:0]  rem_reg, rem_next;
    logic [DIVISOR_BITS-1:0]  dsr_reg, dsr_next;

    logic [DIVISOR_BITS:0]    shifted;
    logic [DIVISOR_BITS:0]    diff;
    logic                     fits;

    // One trial subtraction of the partial remainder.
    assign shifted = {rem_reg, quo_reg[DIVIDEND_BITS-1]};
    assign diff    = shifted - {1'b0, dsr_reg};
    assign fits    = shifted >= {1'b0, dsr_reg};

    // Iteration control and quotient shift register.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(DIVIDEND_BITS);
            quo_next  = dividend;
            rem_next  = '0;
            dsr_next  = divisor;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - CNT_BITS'(1);
            rem_next = fits ? diff[DIVISOR_BITS-1:0] : shifted[DIVISOR_BITS-1:0];
            quo_next = {quo_reg[DIVIDEND_BITS-2:0], fits};
            if (cnt_reg == CNT_BITS'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

### hw/rtl/cwc_datapath.sv
//==============================================================================
// cwc_datapath
// Configuration registers, connection state, window arithmetic and the
// result register of the congestion window controller.
//==============================================================================
`default_nettype none

module cwc_datapath #(
    parameter int WIN_FRAC_BITS = cwc_pkg::WIN_FRAC_BITS_DEF,
    parameter int WIN_INT_BITS  = cwc_pkg::WIN_INT_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [cwc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  wire logic [cwc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  wire logic [1:0]                          opcode,
    input  wire logic [31:0]                         ack_number,
    input  wire cwc_pkg::cwc_cmd_t                   cmd,
    output cwc_pkg::cwc_status_t                     status,
    output logic [31:0]                              resend_first,
    output logic [7:0]                               resend_count,
    output logic [31:0]                              send_first,
    output logic [19:0]                              send_count,
    output logic [31:0]                              window_fixed,
    output logic [19:0]                              threshold_out,
    output logic [1:0]                               phase_out,
    output logic [7:0]                               duplicate_count,
    output logic                                     finished
);

    localparam int WIN_BITS = WIN_INT_BITS + WIN_FRAC_BITS;
    localparam int QUO_BITS = WIN_FRAC_BITS + 1;
    localparam logic [WIN_BITS-1:0] WIN_ONE = WIN_BITS'(1) << WIN_FRAC_BITS;
    localparam logic [WIN_BITS-1:0] WIN_MAX = '1;
    localparam logic [32:0] INT_MAX = 33'((64'(1) << WIN_INT_BITS) - 64'(1));
    localparam logic [WIN_BITS-1:0] WIN_RESET =
        WIN_BITS'(64'(cwc_pkg::INIT_WIN_RST) << WIN_FRAC_BITS);
    localparam logic [QUO_BITS-1:0] DIVIDEND = QUO_BITS'(1) << WIN_FRAC_BITS;

    // Packet count to window, saturating at the all-ones window.
    function automatic logic [WIN_BITS-1:0] win_of_packets(input logic [31:0] n);
        win_of_packets = ({1'b0, n} > INT_MAX) ? WIN_MAX
                       : WIN_BITS'({n, {WIN_FRAC_BITS{1'b0}}});
    endfunction

    // Saturating window addition.
    function automatic logic [WIN_BITS-1:0] win_add(input logic [WIN_BITS-1:0] a,
                                                   input logic [WIN_BITS-1:0] b);
        logic [WIN_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        win_add = s[WIN_BITS] ? WIN_MAX : s[WIN_BITS-1:0];
    endfunction

    // A grown window never drops below one packet.
    function automatic logic [WIN_BITS-1:0] win_floor1(input logic [WIN_BITS-1:0] v);
        win_floor1 = (v < WIN_ONE) ? WIN_ONE : v;
    endfunction

    // Configuration registers.
    logic [31:0] total_reg, total_next;
    logic [19:0] init_thr_reg, init_thr_next;
    logic [19:0] min_thr_reg, min_thr_next;
    logic [19:0] tmo_win_reg, tmo_win_next;
    logic [19:0] init_win_reg, init_win_next;
    logic [7:0]  burst_reg, burst_next;

    // Connection state.
    cwc_pkg::phase_t     phase_reg, phase_next;
    logic [WIN_BITS-1:0] window_reg, window_next;
    logic [19:0]         thr_reg, thr_next;
    logic [7:0]          dup_reg, dup_next;
    logic [31:0]         base_reg, base_next;
    logic [31:0]         next_reg, next_next;
    logic [31:0]         acked_reg, acked_next;
    logic                resend_flag_reg, resend_flag_next;
    logic                send_flag_reg, send_flag_next;

    // Event beat and intermediate results.
    cwc_pkg::opcode_t    op_reg, op_next;
    logic [31:0]         ack_reg, ack_next;
    logic [32:0]         avail_reg, avail_next;
    logic [31:0]         left_reg, left_next;
    logic [7:0]          resend_amt_reg, resend_amt_next;
    logic                fin_reg, fin_next;

    // Result register.
    logic [31:0] o_resend_first_reg, o_resend_first_next;
    logic [7:0]  o_resend_count_reg, o_resend_count_next;
    logic [31:0] o_send_first_reg, o_send_first_next;
    logic [19:0] o_send_count_reg, o_send_count_next;
    logic [31:0] o_window_reg, o_window_next;
    logic [19:0] o_thr_reg, o_thr_next;
    logic [1:0]  o_phase_reg, o_phase_next;
    logic [7:0]  o_dup_reg, o_dup_next;
    logic        o_fin_reg, o_fin_next;

    // Shared terms.
    logic [31:0]             outstanding;
    logic                    is_dup;
    logic [7:0]              dup_inc;
    logic [WIN_INT_BITS-1:0] win_int;
    logic [WIN_INT_BITS-1:0] divisor;
    logic [31:0]             halved_raw;
    logic [31:0]             halved_min;
    logic [19:0]             halved;
    logic [32:0]             ack_plus;
    logic [31:0]             base_new;
    logic [WIN_BITS:0]       ceil_sum;
    logic [32:0]             ceil_win;
    logic [32:0]             send_min;
    logic [19:0]             send_n;
    logic                    div_done;
    logic [QUO_BITS-1:0]     quotient;

    assign outstanding = next_reg - base_reg;
    assign is_dup      = (outstanding != 32'd0) && (ack_reg < base_reg);
    assign dup_inc     = (dup_reg == cwc_pkg::DUP_MAX) ? cwc_pkg::DUP_MAX : dup_reg + 8'd1;
    assign win_int     = window_reg[WIN_BITS-1:WIN_FRAC_BITS];
    assign divisor     = (win_int == '0) ? WIN_INT_BITS'(1) : win_int;

    // Threshold after halving the window, floored and clipped to 20 bits.
    assign halved_raw = 32'(window_reg >> (WIN_FRAC_BITS + 1));
    assign halved_min = (halved_raw < {12'd0, min_thr_reg}) ? {12'd0, min_thr_reg} : halved_raw;
    assign halved     = (halved_min > {12'd0, cwc_pkg::THR_MAX}) ? cwc_pkg::THR_MAX
                      : halved_min[19:0];

    // New base after a cumulative acknowledgement.
    assign ack_plus = {1'b0, ack_reg} + 33'd1;
    assign base_new = (ack_plus < {1'b0, next_reg}) ? ack_plus[31:0] : next_reg;

    // Window rounded up to whole packets.
    assign ceil_sum = {1'b0, window_reg} + (WIN_BITS + 1)'(WIN_ONE - WIN_BITS'(1));
    assign ceil_win = 33'(ceil_sum[WIN_BITS:WIN_FRAC_BITS]);

    // New send count: the smaller of the window room and packets left, clipped.
    assign send_min = ({1'b0, left_reg} < avail_reg) ? {1'b0, left_reg} : avail_reg;
    assign send_n   = (send_min > {13'd0, cwc_pkg::THR_MAX}) ? cwc_pkg::THR_MAX
                    : send_min[19:0];

    assign status.need_div = (op_reg == cwc_pkg::OP_ACK) && !is_dup
                           && (phase_reg == cwc_pkg::PH_AVOID);
    assign status.div_done = div_done;

    // Serial reciprocal for congestion avoidance growth.
    cwc_div #(
        .DIVIDEND_BITS (QUO_BITS),
        .DIVISOR_BITS  (WIN_INT_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (cmd.div_start),
        .dividend (DIVIDEND),
        .divisor  (divisor),
        .done     (div_done),
        .quotient (quotient)
    );

    // Configuration writes.
    always_comb
    begin
        total_next    = total_reg;
        init_thr_next = init_thr_reg;
        min_thr_next  = min_thr_reg;
        tmo_win_next  = tmo_win_reg;
        init_win_next = init_win_reg;
        burst_next    = burst_reg;
        if (cfg_we)
        begin
            case (cfg_index)
                cwc_pkg::CFG_TOTAL:       total_next    = cfg_data;
                cwc_pkg::CFG_INIT_THR:    init_thr_next = cfg_data[19:0];
                cwc_pkg::CFG_MIN_THR:     min_thr_next  = cfg_data[19:0];
                cwc_pkg::CFG_TIMEOUT_WIN: tmo_win_next  = cfg_data[19:0];
                cwc_pkg::CFG_INIT_WIN:    init_win_next = cfg_data[19:0];
                cwc_pkg::CFG_BURST:       burst_next    = cfg_data[7:0];
                default:                  ;
            endcase
        end
    end

    // Event processing and state updates.
    always_comb
    begin
        phase_next       = phase_reg;
        window_next      = window_reg;
        thr_next         = thr_reg;
        dup_next         = dup_reg;
        base_next        = base_reg;
        next_next        = next_reg;
        acked_next       = acked_reg;
        resend_flag_next = resend_flag_reg;
        send_flag_next   = send_flag_reg;
        op_next          = op_reg;
        ack_next         = ack_reg;

        if (cmd.load)
        begin
            op_next  = cwc_pkg::opcode_t'(opcode);
            ack_next = ack_number;
        end

        if (cmd.exec)
        begin
            resend_flag_next = 1'b0;
            send_flag_next   = 1'b0;
            case (op_reg)
                cwc_pkg::OP_START:
                begin
                    phase_next     = cwc_pkg::PH_SLOW;
                    window_next    = win_of_packets(32'(init_win_reg));
                    thr_next       = init_thr_reg;
                    dup_next       = 8'd0;
                    base_next      = 32'd0;
                    next_next      = 32'd0;
                    acked_next     = 32'd0;
                    send_flag_next = 1'b1;
                end
                cwc_pkg::OP_ACK:
                begin
                    if (is_dup)
                    begin
                        dup_next = dup_inc;
                        if (phase_reg == cwc_pkg::PH_RECOVER)
                        begin
                            window_next = win_add(window_reg, WIN_ONE);
                        end
                        else if (dup_inc >= cwc_pkg::DUP_LIMIT)
                        begin
                            phase_next       = cwc_pkg::PH_RECOVER;
                            thr_next         = halved;
                            window_next      = win_of_packets(32'(halved) + 32'd3);
                            resend_flag_next = 1'b1;
                        end
                    end
                    else
                    begin
                        dup_next = 8'd0;
                        case (phase_reg)
                            cwc_pkg::PH_SLOW:
                            begin
                                if (32'(win_int) >= 32'(thr_reg))
                                    phase_next = cwc_pkg::PH_AVOID;
                                else
                                    window_next = win_floor1(win_add(window_reg, WIN_ONE));
                            end
                            cwc_pkg::PH_RECOVER:
                            begin
                                window_next = win_floor1(win_of_packets(32'(thr_reg)));
                                phase_next  = cwc_pkg::PH_AVOID;
                            end
                            // Congestion avoidance grows once the divider is done.
                            default: ;
                        endcase
                        acked_next     = ack_reg;
                        base_next      = base_new;
                        send_flag_next = 1'b1;
                    end
                end
                cwc_pkg::OP_TIMEOUT:
                begin
                    phase_next       = cwc_pkg::PH_SLOW;
                    thr_next         = halved;
                    window_next      = win_of_packets(32'(tmo_win_reg));
                    dup_next         = 8'd0;
                    resend_flag_next = 1'b1;
                end
                default: ;
            endcase
        end

        // Congestion avoidance growth by one over the integer window.
        if (cmd.grow)
            window_next = win_floor1(win_add(window_reg, WIN_BITS'(quotient)));

        if (cmd.emit)
            next_next = next_reg + 32'(send_n);
    end

    // Send room, packets left, resend amount and done flag.
    always_comb
    begin
        avail_next      = avail_reg;
        left_next       = left_reg;
        resend_amt_next = resend_amt_reg;
        fin_next        = fin_reg;
        if (cmd.prep)
        begin
            if (send_flag_reg && (ceil_win > {1'b0, outstanding}))
                avail_next = ceil_win - {1'b0, outstanding};
            else
                avail_next = 33'd0;
            left_next = (total_reg > next_reg) ? total_reg - next_reg : 32'd0;
            if (!resend_flag_reg)
                resend_amt_next = 8'd0;
            else if (outstanding < {24'd0, burst_reg})
                resend_amt_next = outstanding[7:0];
            else
                resend_amt_next = burst_reg;
            fin_next = (total_reg == 32'd0) || (acked_reg >= total_reg - 32'd1);
        end
    end

    // Result register load.
    always_comb
    begin
        o_resend_first_next = o_resend_first_reg;
        o_resend_count_next = o_resend_count_reg;
        o_send_first_next   = o_send_first_reg;
        o_send_count_next   = o_send_count_reg;
        o_window_next       = o_window_reg;
        o_thr_next          = o_thr_reg;
        o_phase_next        = o_phase_reg;
        o_dup_next          = o_dup_reg;
        o_fin_next          = o_fin_reg;
        if (cmd.emit)
        begin
            o_resend_first_next = base_reg;
            o_resend_count_next = resend_amt_reg;
            o_send_first_next   = next_reg;
            o_send_count_next   = send_n;
            o_window_next       = 32'(window_reg);
            o_thr_next          = thr_reg;
            o_phase_next        = phase_reg;
            o_dup_next          = dup_reg;
            o_fin_next          = fin_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            total_reg       <= cwc_pkg::TOTAL_RST;
            init_thr_reg    <= cwc_pkg::INIT_THR_RST;
            min_thr_reg     <= cwc_pkg::MIN_THR_RST;
            tmo_win_reg     <= cwc_pkg::TIMEOUT_WIN_RST;
            init_win_reg    <= cwc_pkg::INIT_WIN_RST;
            burst_reg       <= cwc_pkg::BURST_RST;
            phase_reg       <= cwc_pkg::PH_SLOW;
            window_reg      <= WIN_RESET;
            thr_reg         <= cwc_pkg::INIT_THR_RST;
            dup_reg         <= 8'd0;
            base_reg        <= 32'd0;
            next_reg        <= 32'd0;
            acked_reg       <= 32'd0;
            resend_flag_reg <= 1'b0;
            send_flag_reg   <= 1'b0;
        end
        else
        begin
            total_reg       <= total_next;
            init_thr_reg    <= init_thr_next;
            min_thr_reg     <= min_thr_next;
            tmo_win_reg     <= tmo_win_next;
            init_win_reg    <= init_win_next;
            burst_reg       <= burst_next;
            phase_reg       <= phase_next;
            window_reg      <= window_next;
            thr_reg         <= thr_next;
            dup_reg         <= dup_next;
            base_reg        <= base_next;
            next_reg        <= next_next;
            acked_reg       <= acked_next;
            resend_flag_reg <= resend_flag_next;
            send_flag_reg   <= send_flag_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg             <= op_next;
        ack_reg            <= ack_next;
        avail_reg          <= avail_next;
        left_reg           <= left_next;
        resend_amt_reg     <= resend_amt_next;
        fin_reg            <= fin_next;
        o_resend_first_reg <= o_resend_first_next;
        o_resend_count_reg <= o_resend_count_next;
        o_send_first_reg   <= o_send_first_next;
        o_send_count_reg   <= o_send_count_next;
        o_window_reg       <= o_window_next;
        o_thr_reg          <= o_thr_next;
        o_phase_reg        <= o_phase_next;
        o_dup_reg          <= o_dup_next;
        o_fin_reg          <= o_fin_next;
    end

    assign resend_first    = o_resend_first_reg;
    assign resend_count    = o_resend_count_reg;
    assign send_first      = o_send_first_reg;
    assign send_count      = o_send_count_reg;
    assign window_fixed    = o_window_reg;
    assign threshold_out   = o_thr_reg;
    assign phase_out       = o_phase_reg;
    assign duplicate_count = o_dup_reg;
    assign finished        = o_fin_reg;

endmodule

`default_nettype wire

### hw/rtl/cwc_ctrl.sv
//==============================================================================
// cwc_ctrl
// Sequencer that steps one event beat through the datapath and owns the
// valid flag of the result register.
//==============================================================================
`default_nettype none

module cwc_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    input  wire cwc_pkg::cwc_status_t status,
    output cwc_pkg::cwc_cmd_t         cmd
);

    cwc_pkg::ctrl_state_t state_reg, state_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_free;

    // The result register can take a new beat when empty or being drained.
    assign out_free = !out_valid_reg || out_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            cwc_pkg::ST_IDLE:
            begin
                if (in_valid)
                    state_next = cwc_pkg::ST_EVENT;
            end
            cwc_pkg::ST_EVENT:
            begin
                if (status.need_div)
                    state_next = cwc_pkg::ST_DIV;
                else
                    state_next = cwc_pkg::ST_PREP;
            end
            cwc_pkg::ST_DIV:
            begin
                if (status.div_done)
                    state_next = cwc_pkg::ST_PREP;
            end
            cwc_pkg::ST_PREP:
            begin
                state_next = cwc_pkg::ST_SEND;
            end
            cwc_pkg::ST_SEND:
            begin
                if (out_free)
                    state_next = cwc_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = cwc_pkg::ST_IDLE;
            end
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            cwc_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            cwc_pkg::ST_EVENT:
            begin
                cmd.exec      = 1'b1;
                cmd.div_start = status.need_div;
            end
            cwc_pkg::ST_DIV:
            begin
                cmd.grow = status.div_done;
            end
            cwc_pkg::ST_PREP:
            begin
                cmd.prep = 1'b1;
            end
            cwc_pkg::ST_SEND:
            begin
                cmd.emit = out_free;
            end
            default: ;
        endcase
    end

    // Result valid flag.
    always_comb
    begin
        if (cmd.emit)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= cwc_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

`default_nettype wire

### hw/rtl/tcp_congestion_window_control_unit.sv
//==============================================================================
// tcp_congestion_window_control_unit
// Packet-counting Reno style sender congestion controller: one result beat
// per start, acknowledgement or timeout event beat.
//==============================================================================
// An accepted event beat passes the EVENT and PREP states and is loaded into the
//   result register in SEND; a new acknowledgement in congestion avoidance also waits
//   in DIV, between EVENT and PREP, for the bit-serial reciprocal of the integer
//   window. A new event beat is taken only in IDLE, and a stalled result holds SEND.
// Reset: rst_n clears the sequencer, loads register defaults and the start state;
//   no clearing pass is needed.
`default_nettype none

module tcp_congestion_window_control_unit #(
    parameter int WIN_FRAC_BITS = cwc_pkg::WIN_FRAC_BITS_DEF,
    parameter int WIN_INT_BITS  = cwc_pkg::WIN_INT_BITS_DEF
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [cwc_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  wire logic [cwc_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    cwc_event_if.sink                               events,
    cwc_result_if.source                            results
);

    cwc_pkg::cwc_cmd_t    cmd;
    cwc_pkg::cwc_status_t status;

    // Sequencer.
    cwc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (events.valid),
        .in_ready  (events.ready),
        .out_valid (results.valid),
        .out_ready (results.ready),
        .status    (status),
        .cmd       (cmd)
    );

    // Window arithmetic and state.
    cwc_datapath #(
        .WIN_FRAC_BITS (WIN_FRAC_BITS),
        .WIN_INT_BITS  (WIN_INT_BITS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .opcode          (events.opcode),
        .ack_number      (events.ack_number),
        .cmd             (cmd),
        .status          (status),
        .resend_first    (results.resend_first),
        .resend_count    (results.resend_count),
        .send_first      (results.send_first),
        .send_count      (results.send_count),
        .window_fixed    (results.window_fixed),
        .threshold_out   (results.threshold_out),
        .phase_out       (results.phase_out),
        .duplicate_count (results.duplicate_count),
        .finished        (results.finished)
    );

    // A result beat is never loaded over one that is still waiting.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> (!results.valid || results.ready))
        else $error("result register overwritten while a beat is pending");

    // An accepted event beat is executed in the following cycle.
    a_load_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> cmd.exec)
        else $error("accepted event beat was not executed");

    // A finished reciprocal is always folded into the window.
    a_div_applied: assert property (@(posedge clk) disable iff (!rst_n)
        status.div_done |-> cmd.grow)
        else $error("divider result dropped");

    // No new event beat is taken while a division is running.
    a_busy_during_div: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_start |=> !events.ready)
        else $error("event accepted during division");

endmodule

`default_nettype wire

### bench/tcp_congestion_window_control_unit_tb.sv
//==============================================================================
// tcp_congestion_window_control_unit_tb
// Self-checking bench for the packet-counting congestion window controller.
// A cycle-free model of the controller predicts one result beat per accepted
// event beat. Results are checked field by field in order. Directed tests
// cover the phase changes, register extremes and corner cases. Randomized
// sessions follow with random register settings, sender gaps and sink stalls.
//==============================================================================

module tcp_congestion_window_control_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          FRAC         = cwc_pkg::WIN_FRAC_BITS_DEF;
    localparam logic [63:0] WIN_ONE      = 64'd1 << FRAC;
    localparam logic [63:0] WIN_FULL     =
        (64'd1 << (cwc_pkg::WIN_FRAC_BITS_DEF + cwc_pkg::WIN_INT_BITS_DEF)) - 1;
    localparam int          IDLE_SETTLE  = cwc_pkg::WIN_FRAC_BITS_DEF + 6;
    localparam int          TARGET_ITEMS = 450;

    typedef struct packed {
        logic [31:0] resend_first;
        logic [7:0]  resend_count;
        logic [31:0] send_first;
        logic [19:0] send_count;
        logic [31:0] window_fixed;
        logic [19:0] threshold_out;
        logic [1:0]  phase_out;
        logic [7:0]  duplicate_count;
        logic        finished;
    } cwc_beat_t;

    typedef struct packed {
        logic [31:0] total;
        logic [19:0] init_thr;
        logic [19:0] min_thr;
        logic [19:0] to_win;
        logic [19:0] init_win;
        logic [7:0]  burst;
    } cwc_regs_t;

    logic                               clk;
    logic                               rst_n;
    logic                               cfg_we;
    logic [cwc_pkg::CFG_INDEX_BITS-1:0] cfg_index;
    logic [cwc_pkg::CFG_DATA_BITS-1:0]  cfg_data;

    cwc_event_if  ev_if ();
    cwc_result_if res_if ();

    tcp_congestion_window_control_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .events    (ev_if),
        .results   (res_if)
    );

    // Register copies and controller state of the model.
    logic [31:0] r_total;
    logic [19:0] r_init_thr;
    logic [19:0] r_min_thr;
    logic [19:0] r_to_win;
    logic [19:0] r_init_win;
    logic [7:0]  r_burst;

    cwc_pkg::phase_t m_phase;
    logic [31:0]     m_window;
    logic [19:0]     m_thresh;
    logic [7:0]      m_dups;
    logic [31:0]     m_base;
    logic [31:0]     m_next;
    logic [31:0]     m_acked;

    cwc_beat_t   pending_beats[$];
    int          mismatches;
    int          items_sent;
    bit          sender_gaps;
    bit          sink_stalls;

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit.
    initial
    begin
        #5ms;
        $display("CHECKS FAILED");
        $finish;
    end

    //--------------------------------------------------------------------------
    // Controller model
    //--------------------------------------------------------------------------

    function automatic logic [31:0] clamp_window(logic [63:0] v);
        return (v > WIN_FULL) ? WIN_FULL[31:0] : v[31:0];
    endfunction

    function automatic logic [31:0] packets_to_window(logic [63:0] n);
        return clamp_window(n << FRAC);
    endfunction

    function automatic logic [31:0] at_least_one(logic [31:0] w);
        return (w < WIN_ONE) ? WIN_ONE[31:0] : w;
    endfunction

    function automatic logic [31:0] in_flight();
        return m_next - m_base;
    endfunction

    // Threshold becomes half the window, held between the floor and 20 bits.
    function automatic void halve_into_threshold();
        logic [63:0] h;
        h = {32'd0, m_window} >> (FRAC + 1);
        if (h < r_min_thr)
            h = r_min_thr;
        if (h > cwc_pkg::THR_MAX)
            h = cwc_pkg::THR_MAX;
        m_thresh = h[19:0];
    endfunction

    function automatic logic [7:0] oldest_resend();
        logic [31:0] o;
        o = in_flight();
        return (o < r_burst) ? o[7:0] : r_burst;
    endfunction

    // Sends ceil(window) minus outstanding, limited by packets left and 20 bits.
    function automatic logic [19:0] release_new_packets();
        logic [31:0] o32;
        logic [63:0] left;
        logic [63:0] ceil_w;
        logic [63:0] n;
        o32    = in_flight();
        left   = (r_total > m_next) ? {32'd0, r_total} - {32'd0, m_next} : 64'd0;
        ceil_w = ({32'd0, m_window} + WIN_ONE - 64'd1) >> FRAC;
        n      = (ceil_w > o32) ? ceil_w - o32 : 64'd0;
        if (n > left)
            n = left;
        if (n > cwc_pkg::THR_MAX)
            n = cwc_pkg::THR_MAX;
        m_next = m_next + n[31:0];
        return n[19:0];
    endfunction

    function automatic void load_start_state();
        m_phase  = cwc_pkg::PH_SLOW;
        m_window = packets_to_window(r_init_win);
        m_thresh = r_init_thr;
        m_dups   = '0;
        m_base   = '0;
        m_next   = '0;
        m_acked  = '0;
    endfunction

    function automatic void reset_model();
        r_total    = cwc_pkg::TOTAL_RST;
        r_init_thr = cwc_pkg::INIT_THR_RST;
        r_min_thr  = cwc_pkg::MIN_THR_RST;
        r_to_win   = cwc_pkg::TIMEOUT_WIN_RST;
        r_init_win = cwc_pkg::INIT_WIN_RST;
        r_burst    = cwc_pkg::BURST_RST;
        load_start_state();
    endfunction

    // Applies one event to the model and returns the result beat it causes.
    function automatic cwc_beat_t predict_event(cwc_pkg::opcode_t op, logic [31:0] ack);
        cwc_beat_t   b;
        logic [31:0] first_new;
        logic [19:0] new_cnt;
        logic [7:0]  resend_cnt;
        logic [31:0] d;
        logic [32:0] nb;
        first_new  = m_next;
        new_cnt    = '0;
        resend_cnt = '0;
        case (op)
            cwc_pkg::OP_START:
            begin
                load_start_state();
                first_new = m_next;
                new_cnt   = release_new_packets();
            end
            cwc_pkg::OP_ACK:
            begin
                if (in_flight() != 0 && ack < m_base)
                begin
                    // Duplicate acknowledgement.
                    if (m_dups != cwc_pkg::DUP_MAX)
                        m_dups = m_dups + 8'd1;
                    if (m_phase == cwc_pkg::PH_RECOVER)
                        m_window = clamp_window({32'd0, m_window} + WIN_ONE);
                    else if (m_dups >= cwc_pkg::DUP_LIMIT)
                    begin
                        m_phase = cwc_pkg::PH_RECOVER;
                        halve_into_threshold();
                        m_window   = packets_to_window({44'd0, m_thresh} + 64'd3);
                        resend_cnt = oldest_resend();
                    end
                end
                else
                begin
                    // New acknowledgement, or nothing outstanding.
                    m_dups = '0;
                    case (m_phase)
                        cwc_pkg::PH_SLOW:
                        begin
                            if ((m_window >> FRAC) >= m_thresh)
                                m_phase = cwc_pkg::PH_AVOID;
                            else
                                m_window = at_least_one(
                                    clamp_window({32'd0, m_window} + WIN_ONE));
                        end
                        cwc_pkg::PH_AVOID:
                        begin
                            d = m_window >> FRAC;
                            if (d == 0)
                                d = 1;
                            m_window = at_least_one(
                                clamp_window({32'd0, m_window} + WIN_ONE / d));
                        end
                        default:
                        begin
                            m_window = at_least_one(packets_to_window(m_thresh));
                            m_phase  = cwc_pkg::PH_AVOID;
                        end
                    endcase
                    m_acked = ack;
                    nb      = {1'b0, ack} + 33'd1;
                    m_base  = (nb < {1'b0, m_next}) ? nb[31:0] : m_next;
                    new_cnt = release_new_packets();
                end
            end
            cwc_pkg::OP_TIMEOUT:
            begin
                m_phase = cwc_pkg::PH_SLOW;
                halve_into_threshold();
                m_window   = packets_to_window(r_to_win);
                resend_cnt = oldest_resend();
                m_dups     = '0;
            end
            default:
            begin
                // No operation: state is reported unchanged.
            end
        endcase
        b.resend_first    = m_base;
        b.resend_count    = resend_cnt;
        b.send_first      = first_new;
        b.send_count      = new_cnt;
        b.window_fixed    = m_window;
        b.threshold_out   = m_thresh;
        b.phase_out       = m_phase;
        b.duplicate_count = m_dups;
        b.finished        = (r_total == 0) || (m_acked >= r_total - 32'd1);
        return b;
    endfunction

    //--------------------------------------------------------------------------
    // Driving and checking
    //--------------------------------------------------------------------------

    // Mostly short idle stretches, now and then a long one.
    function automatic int idle_length();
        return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    endfunction

    function automatic void check_field(string name, logic [31:0] exp, logic [31:0] act);
        if (exp !== act)
        begin
            mismatches++;
            $error("%s: expected 0x%0h, actual 0x%0h", name, exp, act);
        end
    endfunction

    // Adds a predicted beat behind all earlier ones.
    function automatic void queue_beat(cwc_beat_t b);
        pending_beats.insert(pending_beats.size(), b);
    endfunction

    // Removes and returns the earliest predicted beat.
    function automatic cwc_beat_t take_oldest_beat();
        cwc_beat_t b;
        b = pending_beats[0];
        pending_beats.delete(0);
        return b;
    endfunction

    // Sends one event beat and records its predicted result once accepted.
    task automatic send_event(cwc_pkg::opcode_t op, logic [31:0] ack);
        int gap;
        gap = (sender_gaps && $urandom_range(0, 99) < 30) ? idle_length() : 0;
        if (gap > 0)
        begin
            ev_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        ev_if.valid      <= 1'b1;
        ev_if.opcode     <= op;
        ev_if.ack_number <= ack;
        @(posedge clk);
        while (!ev_if.ready)
            @(posedge clk);
        queue_beat(predict_event(op, ack));
        items_sent++;
    endtask

    // Holds off new events until every predicted result has been seen.
    task automatic wait_results_drained();
        ev_if.valid <= 1'b0;
        while (pending_beats.size() != 0)
            @(posedge clk);
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    // Writes all six registers; only called while the block is idle.
    task automatic program_regs(cwc_regs_t c);
        cwc_pkg::cfg_index_t idx;
        for (int i = 0; i < 6; i++)
        begin
            idx = cwc_pkg::cfg_index_t'(i);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            case (idx)
                cwc_pkg::CFG_TOTAL:       cfg_data <= c.total;
                cwc_pkg::CFG_INIT_THR:    cfg_data <= {12'd0, c.init_thr};
                cwc_pkg::CFG_MIN_THR:     cfg_data <= {12'd0, c.min_thr};
                cwc_pkg::CFG_TIMEOUT_WIN: cfg_data <= {12'd0, c.to_win};
                cwc_pkg::CFG_INIT_WIN:    cfg_data <= {12'd0, c.init_win};
                default:                  cfg_data <= {24'd0, c.burst};
            endcase
            @(posedge clk);
        end
        cfg_we     <= 1'b0;
        r_total    = c.total;
        r_init_thr = c.init_thr;
        r_min_thr  = c.min_thr;
        r_to_win   = c.to_win;
        r_init_win = c.init_win;
        r_burst    = c.burst;
        @(posedge clk);
    endtask

    // Acknowledges somewhere in the outstanding range, or repeats the last one.
    function automatic logic [31:0] fresh_ack_number();
        logic [31:0] o;
        o = in_flight();
        if (o == 0)
            return m_acked;
        return m_base + $urandom_range(0, (o > 8) ? 7 : o - 1);
    endfunction

    // Acknowledges below the oldest outstanding packet, usually just below.
    function automatic logic [31:0] repeat_ack_number();
        if (m_base == 0)
            return 32'd0;
        return ($urandom_range(0, 3) == 0) ? $urandom_range(0, m_base - 1) : m_base - 1;
    endfunction

    // Result sink: checks each accepted beat and stalls at random.
    initial
    begin
        int        stall_left;
        cwc_beat_t want;
        stall_left = 0;
        res_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && res_if.valid && res_if.ready)
            begin
                if (pending_beats.size() == 0)
                begin
                    mismatches++;
                    $error("result beat arrived with no event pending");
                end
                else
                begin
                    want = take_oldest_beat();
                    check_field("resend_first", want.resend_first, res_if.resend_first);
                    check_field("resend_count", want.resend_count, res_if.resend_count);
                    check_field("send_first", want.send_first, res_if.send_first);
                    check_field("send_count", want.send_count, res_if.send_count);
                    check_field("window_fixed", want.window_fixed, res_if.window_fixed);
                    check_field("threshold_out", want.threshold_out, res_if.threshold_out);
                    check_field("phase_out", want.phase_out, res_if.phase_out);
                    check_field("duplicate_count", want.duplicate_count,
                                res_if.duplicate_count);
                    check_field("finished", want.finished, res_if.finished);
                end
            end
            if (stall_left > 0)
            begin
                res_if.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                res_if.ready <= 1'b1;
                if (sink_stalls && $urandom_range(0, 99) < 20)
                    stall_left = idle_length();
            end
        end
    end

    //--------------------------------------------------------------------------
    // Tests
    //--------------------------------------------------------------------------

    // Reset registers: one packet and its acknowledgement, then an acknowledgement
    // and a timeout with nothing outstanding.
    task automatic test_reset_defaults();
        send_event(cwc_pkg::OP_START, $urandom);
        send_event(cwc_pkg::OP_ACK, 32'd0);
        send_event(cwc_pkg::OP_ACK, 32'd0);
        send_event(cwc_pkg::OP_TIMEOUT, $urandom);
        wait_results_drained();
    endtask

    // Slow start growth up to the threshold, then congestion avoidance.
    task automatic test_growth_phases();
        program_regs('{total: 32'd40, init_thr: 20'd4, min_thr: 20'd2, to_win: 20'd1,
                       init_win: 20'd2, burst: 8'd3});
        send_event(cwc_pkg::OP_START, $urandom);
        repeat (4) send_event(cwc_pkg::OP_ACK, m_base);
    endtask

    // Three duplicates enter fast recovery, a fourth inflates, a new ACK exits.
    task automatic test_fast_recovery();
        repeat (4) send_event(cwc_pkg::OP_ACK, repeat_ack_number());
        send_event(cwc_pkg::OP_ACK, fresh_ack_number());
    endtask

    // Timeout with packets outstanding, the idle opcode and the largest ACK.
    task automatic test_timeout_and_noop();
        send_event(cwc_pkg::OP_TIMEOUT, $urandom);
        send_event(cwc_pkg::OP_NONE, $urandom);
        send_event(cwc_pkg::OP_ACK, 32'hFFFF_FFFF);
        wait_results_drained();
    endtask

    // Every register at its top value: saturated window and full bursts.
    task automatic test_register_extremes();
        program_regs('{total: 32'hFFFF_FFFF, init_thr: 20'hFFFFF, min_thr: 20'hFFFFF,
                       to_win: 20'hFFFFF, init_win: 20'hFFFFF, burst: 8'hFF});
        send_event(cwc_pkg::OP_START, $urandom);
        repeat (2) send_event(cwc_pkg::OP_ACK, m_base);
        repeat (3) send_event(cwc_pkg::OP_ACK, repeat_ack_number());
        send_event(cwc_pkg::OP_ACK, m_base);
        wait_results_drained();
    endtask

    // Zero packets to transfer, other registers at their lowest values.
    task automatic test_zero_total();
        program_regs('{total: 32'd0, init_thr: 20'd1, min_thr: 20'd1, to_win: 20'd1,
                       init_win: 20'd1, burst: 8'd1});
        send_event(cwc_pkg::OP_START, $urandom);
        send_event(cwc_pkg::OP_ACK, $urandom);
        send_event(cwc_pkg::OP_TIMEOUT, $urandom);
        wait_results_drained();
    endtask

    function automatic cwc_regs_t random_regs();
        cwc_regs_t c;
        if ($urandom_range(0, 9) == 0)
        begin
            c.total    = $urandom;
            c.init_thr = $urandom_range(1, 20'hFFFFF);
            c.min_thr  = $urandom_range(1, 20'hFFFFF);
            c.to_win   = $urandom_range(1, 20'hFFFFF);
            c.init_win = $urandom_range(1, 20'hFFFFF);
            c.burst    = $urandom_range(1, 255);
        end
        else
        begin
            c.total    = $urandom_range(1, 400);
            c.init_thr = $urandom_range(1, 40);
            c.min_thr  = $urandom_range(1, 16);
            c.to_win   = $urandom_range(1, 8);
            c.init_win = $urandom_range(1, 12);
            c.burst    = $urandom_range(1, 40);
        end
        return c;
    endfunction

    // Sessions of mostly well-formed traffic: progressing and duplicate ACKs,
    // with timeouts, restarts, stray ACK numbers and idle opcodes mixed in.
    task automatic test_random_traffic();
        int  session_len;
        int  pick;
        bit  drained_once;
        drained_once = 1'b0;
        while (items_sent < TARGET_ITEMS)
        begin
            wait_results_drained();
            program_regs(random_regs());
            sender_gaps = ($urandom_range(0, 3) != 0);
            sink_stalls = ($urandom_range(0, 3) != 0);
            send_event(cwc_pkg::OP_START, $urandom);
            session_len = $urandom_range(15, 50);
            for (int k = 0; k < session_len; k++)
            begin
                if (k == session_len / 2 && (!drained_once || $urandom_range(0, 3) == 0))
                begin
                    wait_results_drained();
                    drained_once = 1'b1;
                end
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    send_event(cwc_pkg::OP_ACK, fresh_ack_number());
                else if (pick < 78)
                    repeat ($urandom_range(1, 5))
                        send_event(cwc_pkg::OP_ACK, repeat_ack_number());
                else if (pick < 86)
                    send_event(cwc_pkg::OP_TIMEOUT, $urandom);
                else if (pick < 90)
                    send_event(cwc_pkg::OP_START, $urandom);
                else if (pick < 95)
                    send_event(cwc_pkg::OP_ACK, $urandom);
                else
                    send_event(cwc_pkg::OP_NONE, $urandom);
            end
        end
    endtask

    //--------------------------------------------------------------------------
    // Sequence
    //--------------------------------------------------------------------------

    initial
    begin
        mismatches  = 0;
        items_sent  = 0;
        sender_gaps = 1'b1;
        sink_stalls = 1'b1;
        rst_n            <= 1'b0;
        cfg_we           <= 1'b0;
        cfg_index        <= cwc_pkg::CFG_TOTAL;
        cfg_data         <= '0;
        ev_if.valid      <= 1'b0;
        ev_if.opcode     <= cwc_pkg::OP_NONE;
        ev_if.ack_number <= '0;
        reset_model();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_growth_phases();
        test_fast_recovery();
        test_timeout_and_noop();
        test_register_extremes();
        test_zero_total();
        test_random_traffic();

        wait_results_drained();
        repeat (40) @(posedge clk);
        if (pending_beats.size() != 0)
        begin
            mismatches++;
            $error("%0d expected result beats never arrived", pending_beats.size());
        end
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
